// File: hw/rtl/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

  // Field widths fixed by the item formats
  localparam int PosW     = 24;
  localparam int HeightW  = 16;
  localparam int ResultW  = 24;
  localparam int FracW    = 16;
  localparam int ScaleW   = 16;
  localparam int DimW     = 9;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Grid coordinate: (pos - origin) * scale, Q.16, signed
  localparam int CoordW = PosW + 1 + ScaleW;

  // Half a sample in Q.16, for round-half-up of the hole lookup
  localparam int HalfSample = 32768;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_X      = 3'd0,
    REG_BASE_Y      = 3'd1,
    REG_SCALE       = 3'd2,
    REG_MAP_WIDTH   = 3'd3,
    REG_MAP_HEIGHT  = 3'd4,
    REG_HOLE_ENABLE = 3'd5
  } cfg_reg_t;

  // Load enables of the pipeline stages
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
  } pipe_en_t;

  // Four neighbor heights and the nearest hole bit
  typedef struct packed {
    logic signed [HeightW-1:0] z00;
    logic signed [HeightW-1:0] z10;
    logic signed [HeightW-1:0] z01;
    logic signed [HeightW-1:0] z11;
    logic                      hole;
  } quad_t;

endpackage

`default_nettype wire

// File: hw/rtl/hbs_ifs.sv
`default_nettype none

interface hbs_item_if import hbs_pkg::*;;
  logic                      valid;
  logic                      ready;
  op_t                       opcode;
  logic signed [PosW-1:0]    x_pos;
  logic signed [PosW-1:0]    y_pos;
  logic [7:0]                load_col;
  logic [7:0]                load_row;
  logic signed [HeightW-1:0] load_height;
  logic                      load_hole;

  modport source (
    output valid, opcode, x_pos, y_pos, load_col, load_row, load_height, load_hole,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_pos, y_pos, load_col, load_row, load_height, load_hole,
    output ready
  );
endinterface

interface hbs_result_if import hbs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [ResultW-1:0] height;
  logic                      in_hole;

  modport source (output valid, height, in_hole, input ready);
  modport sink (input valid, height, in_hole, output ready);
endinterface

interface hbs_cfg_if import hbs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hbs_axis.sv
`default_nettype none

// One axis of the coordinate map: subtract origin, scale, then clamp for
// the bilinear corners and round to the nearest sample for the hole lookup.
module hbs_axis import hbs_pkg::*; #(
  parameter int DIM_MAX = 256,
  localparam int IdxW = $clog2(DIM_MAX)
) (
  input  wire logic                   clk,
  input  wire pipe_en_t               en,
  input  wire logic signed [PosW-1:0] pos,
  input  wire logic signed [PosW-1:0] origin,
  input  wire logic [ScaleW-1:0]      scale,
  input  wire logic [DimW-1:0]        dim,
  output logic [IdxW-1:0]             idx0,
  output logic [IdxW-1:0]             idx1,
  output logic [FracW-1:0]            frac,
  output logic [IdxW-1:0]             near
);

  localparam int DiffW = PosW + 1;
  localparam int LimW  = IdxW + FracW;
  localparam int MagW  = CoordW - 1;
  localparam int NearW = MagW - FracW;
  localparam logic [12:0] DimMax = 13'(DIM_MAX);

  logic signed [DiffW-1:0]  diff;
  logic signed [CoordW-1:0] coord;
  logic signed [ScaleW:0]   scale_s;
  logic [12:0]              dim_ext;
  logic [IdxW-1:0]          last;
  logic [LimW-1:0]          limit;
  logic [LimW-1:0]          fx;
  logic [IdxW-1:0]          i0;
  logic signed [CoordW-1:0] hc;
  logic [NearW-1:0]         hn;
  logic [IdxW-1:0]          near_next;

  assign scale_s = $signed({1'b0, scale});
  assign dim_ext = 13'(dim);

  // Last usable index: zero acts as one, large values saturate
  always_comb begin
    if (dim == '0) begin
      last = '0;
    end else if (dim_ext > DimMax) begin
      last = IdxW'(DimMax - 13'd1);
    end else begin
      last = IdxW'(dim_ext - 13'd1);
    end
  end

  // Stage A: offset from origin
  always_ff @(posedge clk) begin
    if (en.a) begin
      diff <= DiffW'(pos) - DiffW'(origin);
    end
  end

  // Stage B: scale into grid units
  always_ff @(posedge clk) begin
    if (en.b) begin
      coord <= diff * scale_s;
    end
  end

  // Clamp into the grid for the bilinear corners
  assign limit = {last, FracW'(0)};
  always_comb begin
    if (coord[CoordW-1]) begin
      fx = '0;
    end else if (coord[MagW-1:0] > MagW'(limit)) begin
      fx = limit;
    end else begin
      fx = coord[LimW-1:0];
    end
  end
  assign i0 = fx[LimW-1:FracW];

  // Round half up, then clamp, for the nearest sample
  assign hc = coord + CoordW'(HalfSample);
  assign hn = hc[MagW-1:FracW];
  always_comb begin
    if (hc[CoordW-1]) begin
      near_next = '0;
    end else if (hn > NearW'(last)) begin
      near_next = last;
    end else begin
      near_next = hn[IdxW-1:0];
    end
  end

  // Stage C: grid indices and fraction
  always_ff @(posedge clk) begin
    if (en.c) begin
      idx0 <= i0;
      idx1 <= (i0 == last) ? i0 : i0 + 1'b1;
      frac <= fx[FracW-1:0];
      near <= near_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hbs_grid_mem.sv
`default_nettype none

// Height grid in four banks by row and column parity, so the four bilinear
// neighbors come out in one read; the hole mask is a plain one-bit memory.
module hbs_grid_mem import hbs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int ColW = $clog2(MAX_WIDTH),
  localparam int RowW = $clog2(MAX_HEIGHT)
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic                      we,
  input  wire logic [RowW-1:0]           wrow,
  input  wire logic [ColW-1:0]           wcol,
  input  wire logic signed [HeightW-1:0] wheight,
  input  wire logic                      whole,
  input  wire logic [ColW-1:0]           i0,
  input  wire logic [ColW-1:0]           i1,
  input  wire logic [RowW-1:0]           j0,
  input  wire logic [RowW-1:0]           j1,
  input  wire logic [ColW-1:0]           hi,
  input  wire logic [RowW-1:0]           hj,
  output quad_t                          quad
);

  localparam int HalfCols  = (MAX_WIDTH + 1) / 2;
  localparam int HalfRows  = (MAX_HEIGHT + 1) / 2;
  localparam int HcolW     = (HalfCols > 1) ? $clog2(HalfCols) : 1;
  localparam int HrowW     = (HalfRows > 1) ? $clog2(HalfRows) : 1;
  localparam int BankAw    = HrowW + HcolW;
  localparam int BankDepth = 2 ** BankAw;
  localparam int HoleAw    = RowW + ColW;
  localparam int HoleDepth = 2 ** HoleAw;

  logic [HeightW-1:0] q [4];
  logic               pr0, pr1, pc0, pc1;
  logic               hole_q;
  logic [BankAw-1:0]  waddr;
  logic               hole_mem [HoleDepth];

  assign waddr = {HrowW'(wrow >> 1), HcolW'(wcol >> 1)};

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    localparam logic Rp = 1'((gb >> 1) & 1);
    localparam logic Cp = 1'(gb & 1);

    logic [HeightW-1:0] bank [BankDepth];
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    col;
    logic [BankAw-1:0]  raddr;

    // Pick the neighbor whose parity lands in this bank
    assign row   = (j0[0] == Rp) ? j0 : j1;
    assign col   = (i0[0] == Cp) ? i0 : i1;
    assign raddr = {HrowW'(row >> 1), HcolW'(col >> 1)};

    always_ff @(posedge clk) begin
      if (en) begin
        q[gb] <= bank[raddr];
        if (we && wrow[0] == Rp && wcol[0] == Cp) begin
          bank[waddr] <= wheight;
        end
      end
    end
  end

  // Hole mask read and write
  always_ff @(posedge clk) begin
    if (en) begin
      hole_q <= hole_mem[{hj, hi}];
      if (we) begin
        hole_mem[{wrow, wcol}] <= whole;
      end
    end
  end

  // Hold parities to route bank outputs to corners
  always_ff @(posedge clk) begin
    if (en) begin
      pr0 <= j0[0];
      pr1 <= j1[0];
      pc0 <= i0[0];
      pc1 <= i1[0];
    end
  end

  assign quad.z00  = $signed(q[{pr0, pc0}]);
  assign quad.z10  = $signed(q[{pr0, pc1}]);
  assign quad.z01  = $signed(q[{pr1, pc0}]);
  assign quad.z11  = $signed(q[{pr1, pc1}]);
  assign quad.hole = hole_q;

endmodule

`default_nettype wire

// File: hw/rtl/hbs_blend.sv
`default_nettype none

// Two-pass bilinear blend: rows along x in stage E, then along y into the
// output register in stage F.
module hbs_blend import hbs_pkg::*; (
  input  wire logic               clk,
  input  wire pipe_en_t           en,
  input  wire quad_t              quad,
  input  wire logic [FracW-1:0]   tx,
  input  wire logic [FracW-1:0]   ty,
  input  wire logic               hole_enable,
  output logic signed [ResultW-1:0] height,
  output logic                    in_hole
);

  localparam int DeltaW = HeightW + 1;
  localparam int ProdW  = 2 * DeltaW;
  localparam int RowW   = 32;
  localparam int DiffW  = RowW + 1;
  localparam int SumW   = 50;

  logic signed [FracW:0]    tx_s;
  logic signed [FracW:0]    ty_s;
  logic signed [DeltaW-1:0] d0, d1;
  logic signed [ProdW-1:0]  p0, p1;
  logic signed [RowW-1:0]   ra, rb;
  logic [FracW-1:0]         ty_e;
  logic                     hole_e;
  logic signed [DiffW-1:0]  dr;
  logic signed [SumW-1:0]   pr;
  logic signed [SumW-1:0]   r;

  assign tx_s = $signed({1'b0, tx});
  assign d0   = DeltaW'(quad.z10) - DeltaW'(quad.z00);
  assign d1   = DeltaW'(quad.z11) - DeltaW'(quad.z01);
  assign p0   = d0 * tx_s;
  assign p1   = d1 * tx_s;

  // Stage E: blend each row along x
  always_ff @(posedge clk) begin
    if (en.e) begin
      ra     <= RowW'((ProdW'(quad.z00) <<< FracW) + p0);
      rb     <= RowW'((ProdW'(quad.z01) <<< FracW) + p1);
      ty_e   <= ty;
      hole_e <= hole_enable & quad.hole;
    end
  end

  assign ty_s = $signed({1'b0, ty_e});
  assign dr   = DiffW'(rb) - DiffW'(ra);
  assign pr   = dr * ty_s;
  assign r    = (SumW'(ra) <<< FracW) + pr;

  // Stage F: blend along y, drop 24 fraction bits toward minus infinity
  always_ff @(posedge clk) begin
    if (en.f) begin
      height  <= r[ResultW+23:24];
      in_hole <= hole_e;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/heightmap_bilinear_sampler.sv
`default_nettype none

// Heightmap bilinear sampler. Takes one item per cycle unless a stalled result
// side backs the full pipeline up: a load writes one height sample and hole bit
// into the grid, a query returns the bilinear height (clamped to the grid edges)
// and the nearest-sample hole bit. A query result waits in the output register
// until the result side takes it; loads produce no result and leave the
// pipeline at the memory stage.
// The six stages are origin subtract, scale multiply, clamp/index, banked
// grid read, x blend and y blend; the grid is split into four banks by row
// and column parity so the four neighbors come from one read. A stalled
// result holds in the output register while earlier stages keep filling.
// Grid contents are undefined until written. Configuration writes are never
// stalled and must only happen while no item is in flight.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  hbs_cfg_if.sink       cfg,
  hbs_item_if.sink      item,
  hbs_result_if.source  result
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam logic [15:0] MaxCols = 16'(MAX_WIDTH);
  localparam logic [15:0] MaxRows = 16'(MAX_HEIGHT);

  // Configuration registers
  logic signed [PosW-1:0] base_x;
  logic signed [PosW-1:0] base_y;
  logic [ScaleW-1:0]      scale;
  logic [DimW-1:0]        map_width;
  logic [DimW-1:0]        map_height;
  logic                   hole_enable;

  // Stage valids and load enables
  logic     valid_a, valid_b, valid_c, valid_d, valid_e, valid_f;
  pipe_en_t en;

  // Load fields through stages A to C
  op_t                       op_a, op_b, op_c;
  logic                      ok_a, ok_b, ok_c;
  logic [ColW-1:0]           col_a, col_b, col_c;
  logic [RowW-1:0]           row_a, row_b, row_c;
  logic signed [HeightW-1:0] hgt_a, hgt_b, hgt_c;
  logic                      hole_a, hole_b, hole_c;

  // Axis results and memory stage carry
  logic [ColW-1:0]  i0, i1, hi;
  logic [RowW-1:0]  j0, j1, hj;
  logic [FracW-1:0] tx, ty, tx_d, ty_d;
  logic             we;
  quad_t            quad;

  // Configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base_x      <= '0;
      base_y      <= '0;
      scale       <= 16'd256;
      map_width   <= 9'd256;
      map_height  <= 9'd256;
      hole_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE_X:      base_x      <= $signed(cfg.data[PosW-1:0]);
        REG_BASE_Y:      base_y      <= $signed(cfg.data[PosW-1:0]);
        REG_SCALE:       scale       <= cfg.data[ScaleW-1:0];
        REG_MAP_WIDTH:   map_width   <= cfg.data[DimW-1:0];
        REG_MAP_HEIGHT:  map_height  <= cfg.data[DimW-1:0];
        REG_HOLE_ENABLE: hole_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its content moves on
  always_comb begin
    en.f = !valid_f || result.ready;
    en.e = !valid_e || en.f;
    en.d = !valid_d || en.e;
    en.c = !valid_c || en.d;
    en.b = !valid_b || en.c;
    en.a = !valid_a || en.b;
  end
  assign item.ready = en.a;

  // Stage valids; loads drop out after the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
      valid_e <= 1'b0;
      valid_f <= 1'b0;
    end else begin
      if (en.a) valid_a <= item.valid;
      if (en.b) valid_b <= valid_a;
      if (en.c) valid_c <= valid_b;
      if (en.d) valid_d <= valid_c && op_c == OP_QUERY;
      if (en.e) valid_e <= valid_d;
      if (en.f) valid_f <= valid_e;
    end
  end

  // Carry load fields to the memory stage
  always_ff @(posedge clk) begin
    if (en.a) begin
      op_a   <= item.opcode;
      ok_a   <= (16'(item.load_col) < MaxCols) && (16'(item.load_row) < MaxRows);
      col_a  <= ColW'(item.load_col);
      row_a  <= RowW'(item.load_row);
      hgt_a  <= item.load_height;
      hole_a <= item.load_hole;
    end
    if (en.b) begin
      op_b   <= op_a;
      ok_b   <= ok_a;
      col_b  <= col_a;
      row_b  <= row_a;
      hgt_b  <= hgt_a;
      hole_b <= hole_a;
    end
    if (en.c) begin
      op_c   <= op_b;
      ok_c   <= ok_b;
      col_c  <= col_b;
      row_c  <= row_b;
      hgt_c  <= hgt_b;
      hole_c <= hole_b;
    end
  end

  hbs_axis #(.DIM_MAX(MAX_WIDTH)) u_axis_x (
    .clk    (clk),
    .en     (en),
    .pos    (item.x_pos),
    .origin (base_x),
    .scale  (scale),
    .dim    (map_width),
    .idx0   (i0),
    .idx1   (i1),
    .frac   (tx),
    .near   (hi)
  );

  hbs_axis #(.DIM_MAX(MAX_HEIGHT)) u_axis_y (
    .clk    (clk),
    .en     (en),
    .pos    (item.y_pos),
    .origin (base_y),
    .scale  (scale),
    .dim    (map_height),
    .idx0   (j0),
    .idx1   (j1),
    .frac   (ty),
    .near   (hj)
  );

  // Write on the same stage edge as query reads, so grid order follows items
  assign we = en.d && valid_c && op_c == OP_LOAD && ok_c;

  hbs_grid_mem #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_grid (
    .clk     (clk),
    .en      (en.d),
    .we      (we),
    .wrow    (row_c),
    .wcol    (col_c),
    .wheight (hgt_c),
    .whole   (hole_c),
    .i0      (i0),
    .i1      (i1),
    .j0      (j0),
    .j1      (j1),
    .hi      (hi),
    .hj      (hj),
    .quad    (quad)
  );

  // Hold fractions alongside the read data
  always_ff @(posedge clk) begin
    if (en.d) begin
      tx_d <= tx;
      ty_d <= ty;
    end
  end

  hbs_blend u_blend (
    .clk         (clk),
    .en          (en),
    .quad        (quad),
    .tx          (tx_d),
    .ty          (ty_d),
    .hole_enable (hole_enable),
    .height      (result.height),
    .in_hole     (result.in_hole)
  );

  assign result.valid = valid_f;

  // Input backpressure only when every stage is occupied and the output stalls
  assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> valid_a && valid_b && valid_c && valid_d && valid_e && valid_f
                    && !result.ready)
    else $error("input stalled with a free pipeline stage");

  // A load leaving the memory stage never becomes a result
  assert property (@(posedge clk) disable iff (rst)
    we |=> !valid_d)
    else $error("load item entered the blend stages");

  // Output register holds while it has a result and the sink stalls
  assert property (@(posedge clk) disable iff (rst)
    valid_f && !result.ready |=> valid_f && $stable(result.height))
    else $error("pending result lost under stall");

endmodule

`default_nettype wire

// File: tb/tb_heightmap_bilinear_sampler.sv
module tb_heightmap_bilinear_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int GRID_W       = 256;
  localparam int GRID_H       = 256;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    op_t                       op;
    logic signed [PosW-1:0]    x;
    logic signed [PosW-1:0]    y;
    logic [7:0]                col;
    logic [7:0]                row;
    logic signed [HeightW-1:0] z;
    logic                      hole;
  } grid_item_t;

  typedef struct packed {
    logic signed [ResultW-1:0] height;
    logic                      in_hole;
  } height_sample_t;

  // Neighbor indices and fractions of one query point
  typedef struct {
    int     i0, i1, j0, j1, hi, hj;
    longint tx, ty;
  } grid_pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hbs_cfg_if    cfg_bus ();
  hbs_item_if   item_bus ();
  hbs_result_if res_bus ();

  heightmap_bilinear_sampler #(
    .MAX_WIDTH  (GRID_W),
    .MAX_HEIGHT (GRID_H)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (res_bus)
  );

  always #10 clk = ~clk;

  // Shadow of the register file
  longint                base_x_q   = 0;
  longint                base_y_q   = 0;
  logic [ScaleW-1:0]     scale_q    = 16'd256;
  logic [DimW-1:0]       width_q    = 9'd256;
  logic [DimW-1:0]       height_q   = 9'd256;
  logic                  hole_en_q  = 1'b0;

  // Shadow of the grid, with a mark for every sample written so far
  logic signed [HeightW-1:0] grid_z       [GRID_W*GRID_H];
  bit                        grid_hole    [GRID_W*GRID_H];
  bit                        grid_written [GRID_W*GRID_H];

  height_sample_t heights_due[$];

  int mismatches = 0;
  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;
  int rx_hold    = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint eff_dim(input logic [DimW-1:0] d, input longint top);
    if (d == 0) return 1;
    if (d > top) return top;
    return longint'(d);
  endfunction

  // Map a world point to grid neighbors, fractions and nearest sample
  function automatic grid_pick_t locate(input logic signed [PosW-1:0] xp,
                                        input logic signed [PosW-1:0] yp);
    grid_pick_t p;
    longint     cx, cy, fx, fy, w, h;
    w  = eff_dim(width_q, GRID_W);
    h  = eff_dim(height_q, GRID_H);
    cx = (longint'(xp) - base_x_q) * longint'(scale_q);
    cy = (longint'(yp) - base_y_q) * longint'(scale_q);
    fx = clamp(cx, 0, (w - 1) * 65536);
    fy = clamp(cy, 0, (h - 1) * 65536);
    p.i0 = int'(fx >>> FracW);
    p.j0 = int'(fy >>> FracW);
    p.tx = fx % 65536;
    p.ty = fy % 65536;
    p.i1 = (p.i0 + 1 < w) ? p.i0 + 1 : p.i0;
    p.j1 = (p.j0 + 1 < h) ? p.j0 + 1 : p.j0;
    p.hi = int'(clamp((cx + HalfSample) >>> FracW, 0, w - 1));
    p.hj = int'(clamp((cy + HalfSample) >>> FracW, 0, h - 1));
    return p;
  endfunction

  // Bilinear height and nearest hole bit at a world point
  function automatic height_sample_t blend_height(input logic signed [PosW-1:0] xp,
                                                  input logic signed [PosW-1:0] yp);
    grid_pick_t     p;
    longint         z00, z10, z01, z11, a, b, r;
    height_sample_t s;
    p   = locate(xp, yp);
    z00 = grid_z[p.j0 * GRID_W + p.i0];
    z10 = grid_z[p.j0 * GRID_W + p.i1];
    z01 = grid_z[p.j1 * GRID_W + p.i0];
    z11 = grid_z[p.j1 * GRID_W + p.i1];
    a   = z00 * 65536 + (z10 - z00) * p.tx;
    b   = z01 * 65536 + (z11 - z01) * p.tx;
    r   = a * 65536 + (b - a) * p.ty;
    r   = r >>> 24;
    s.height  = r[ResultW-1:0];
    s.in_hole = hole_en_q ? grid_hole[p.hj * GRID_W + p.hi] : 1'b0;
    return s;
  endfunction

  function automatic grid_item_t rand_item(input op_t op);
    grid_item_t it;
    it.op   = op;
    it.x    = PosW'($urandom);
    it.y    = PosW'($urandom);
    it.col  = 8'($urandom);
    it.row  = 8'($urandom);
    it.z    = HeightW'($urandom);
    it.hole = 1'($urandom);
    return it;
  endfunction

  function automatic logic signed [HeightW-1:0] rand_z();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return HeightW'($urandom);
    endcase
  endfunction

  function automatic logic signed [PosW-1:0] rand_origin();
    case ($urandom_range(0, 7))
      0:       return 24'sh800000;
      1:       return 24'sh7FFFFF;
      2, 3:    return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      default: return PosW'($urandom);
    endcase
  endfunction

  function automatic logic [DimW-1:0] rand_dim();
    case ($urandom_range(0, 7))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd2;
      3:       return 9'd256;
      4:       return DimW'($urandom_range(257, 511));
      default: return DimW'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic signed [PosW-1:0] rand_edge_pos();
    case ($urandom_range(0, 3))
      0:       return 24'sh800000;
      1:       return 24'sh7FFFFF;
      2:       return 24'sh000000;
      default: return 24'shFFFFFF;
    endcase
  endfunction

  // World position whose grid coordinate lands near the grid on one axis
  function automatic logic signed [PosW-1:0] pos_near_grid(input longint org,
                                                           input longint dim);
    longint target, delta;
    if (scale_q == 0) return PosW'($urandom);
    target = longint'($urandom_range(0, 32'((dim + 5) * 65536))) - 3 * 65536;
    delta  = target / longint'(scale_q) + longint'($urandom_range(0, 2)) - 1;
    return PosW'(org + delta);
  endfunction

  // Offer one item, wait for its transfer, then update the shadow state
  task automatic send_item(input grid_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.opcode      <= it.op;
    item_bus.x_pos       <= it.x;
    item_bus.y_pos       <= it.y;
    item_bus.load_col    <= it.col;
    item_bus.load_row    <= it.row;
    item_bus.load_height <= it.z;
    item_bus.load_hole   <= it.hole;
    do @(posedge clk); while (!item_bus.ready);
    if (it.op == OP_LOAD) begin
      grid_z[it.row * GRID_W + it.col]       = it.z;
      grid_hole[it.row * GRID_W + it.col]    = it.hole;
      grid_written[it.row * GRID_W + it.col] = 1'b1;
    end else begin
      heights_due.push_back(blend_height(it.x, it.y));
    end
  endtask

  task automatic load_cell(input int row, input int col, input logic signed [HeightW-1:0] z,
                           input logic hole);
    grid_item_t it;
    it      = rand_item(OP_LOAD);
    it.row  = 8'(row);
    it.col  = 8'(col);
    it.z    = z;
    it.hole = hole;
    send_item(it);
  endtask

  task automatic fill_cell(input int row, input int col);
    if (!grid_written[row * GRID_W + col]) load_cell(row, col, rand_z(), 1'($urandom));
  endtask

  // Load any sample the query would read that is still unwritten, then query
  task automatic query_point(input logic signed [PosW-1:0] xp, input logic signed [PosW-1:0] yp);
    grid_pick_t p;
    grid_item_t it;
    p = locate(xp, yp);
    fill_cell(p.j0, p.i0);
    fill_cell(p.j0, p.i1);
    fill_cell(p.j1, p.i0);
    fill_cell(p.j1, p.i1);
    fill_cell(p.hj, p.hi);
    it   = rand_item(OP_QUERY);
    it.x = xp;
    it.y = yp;
    send_item(it);
  endtask

  // Drop valid, wait for every result, then let loads drain
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_BASE_X:      base_x_q   = longint'($signed(val));
      REG_BASE_Y:      base_y_q   = longint'($signed(val));
      REG_SCALE:       scale_q    = val[ScaleW-1:0];
      REG_MAP_WIDTH:   width_q    = val[DimW-1:0];
      REG_MAP_HEIGHT:  height_q   = val[DimW-1:0];
      REG_HOLE_ENABLE: hole_en_q  = val[0];
      default: ;
    endcase
  endtask

  // Write all registers back to back while the block is idle
  task automatic set_config(input logic signed [PosW-1:0] ox, input logic signed [PosW-1:0] oy,
                            input logic [ScaleW-1:0] scale, input logic [DimW-1:0] w,
                            input logic [DimW-1:0] h, input logic hole_en);
    settle();
    write_reg(REG_BASE_X, ox);
    write_reg(REG_BASE_Y, oy);
    write_reg(REG_SCALE, CfgDataW'(scale));
    write_reg(REG_MAP_WIDTH, CfgDataW'(w));
    write_reg(REG_MAP_HEIGHT, CfgDataW'(h));
    write_reg(REG_HOLE_ENABLE, CfgDataW'(hole_en));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Reset settings: extreme heights around the origin, far clamps on both sides
  task automatic test_reset_defaults();
    load_cell(0, 0, 16'sh8000, 1'b1);
    load_cell(0, 1, 16'sh7FFF, 1'b0);
    load_cell(1, 0, 16'sh7FFF, 1'b1);
    load_cell(1, 1, 16'sh8000, 1'b0);
    query_point(24'sh000080, 24'sh000080);
    query_point(24'sh000040, 24'sh0000C0);
    query_point(24'sh0000FF, 24'sh000000);
    query_point(24'sh800000, 24'sh800000);
    query_point(24'sh7FFFFF, 24'sh7FFFFF);
  endtask

  // Nearest hole lookup on a 2x2 grid: exact halves round up, edges clamp
  task automatic test_hole_rounding();
    set_config(-24'sd512, 24'sd0, 16'd256, 9'd2, 9'd2, 1'b1);
    query_point(-24'sd384, 24'sd0);
    query_point(-24'sd385, 24'sd127);
    query_point(-24'sd512, 24'sd128);
    query_point(-24'sd128, 24'sd384);
    query_point(24'sh800000, 24'sh7FFFFF);
  endtask

  // Zero and oversized dimensions, scale extremes, origin extremes
  task automatic test_dimension_limits();
    set_config(24'sd0, 24'sd0, 16'hFFFF, 9'd0, 9'd0, 1'b1);
    query_point(24'sh000123, -24'sd5);
    query_point(24'sh7FFFFF, 24'sh800000);
    set_config(24'sh7FFFFF, 24'sh800000, 16'd1, 9'd511, 9'd300, 1'b1);
    query_point(24'sh800000, 24'sh7FFFFF);
    query_point(24'sh7FFFFF, 24'sh800000);
    set_config(24'sh800000, 24'sh123456, 16'd0, 9'd256, 9'd256, 1'b0);
    query_point(PosW'($urandom), PosW'($urandom));
    query_point(PosW'($urandom), PosW'($urandom));
  endtask

  // Hold the result side off while queries arrive back to back
  task automatic test_backpressure();
    set_config(24'sd0, 24'sd0, 16'd256, 9'd16, 9'd16, 1'b1);
    tx_quiet = 1'b1;
    rx_hold  = HOLD_CYCLES;
    repeat (40) begin
      query_point(pos_near_grid(base_x_q, 16), pos_near_grid(base_y_q, 16));
    end
    tx_quiet = 1'b0;
  endtask

  // Random settings, each followed by a mix of loads and queries
  task automatic test_random_mix();
    logic [ScaleW-1:0] scale;
    grid_item_t        it;
    int                pick;
    longint            w, h;
    repeat (6) begin
      case ($urandom_range(0, 9))
        0:       scale = 16'd0;
        1:       scale = 16'd1;
        2:       scale = 16'hFFFF;
        3, 4, 5: scale = 16'd256;
        default: scale = ScaleW'($urandom);
      endcase
      set_config(rand_origin(), rand_origin(), scale, rand_dim(), rand_dim(),
                 1'($urandom_range(0, 1)));
      w = eff_dim(width_q, GRID_W);
      h = eff_dim(height_q, GRID_H);
      repeat (25) begin
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          it   = rand_item(OP_LOAD);
          it.z = rand_z();
          if ($urandom_range(0, 1)) begin
            it.col = 8'($urandom_range(0, 32'(w - 1)));
            it.row = 8'($urandom_range(0, 32'(h - 1)));
          end
          send_item(it);
        end else if (pick < 85) begin
          query_point(pos_near_grid(base_x_q, w), pos_near_grid(base_y_q, h));
        end else if (pick < 93) begin
          query_point(PosW'($urandom), PosW'($urandom));
        end else begin
          query_point(rand_edge_pos(), rand_edge_pos());
        end
      end
    end
    tx_quiet = 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    item_bus.valid       <= 1'b0;
    item_bus.opcode      <= OP_LOAD;
    item_bus.x_pos       <= '0;
    item_bus.y_pos       <= '0;
    item_bus.load_col    <= '0;
    item_bus.load_row    <= '0;
    item_bus.load_height <= '0;
    item_bus.load_hole   <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= REG_BASE_X;
    cfg_bus.data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_hole_rounding();
    test_dimension_limits();
    test_backpressure();
    test_random_mix();
    settle();
    if (mismatches == 0 && heights_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold on request, check each transfer
  initial begin : result_check
    int             gap;
    height_sample_t want;
    res_bus.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        gap = rx_quiet ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
      if (heights_due.size() == 0) begin
        note_error($sformatf("result with no query outstanding: height %0d hole %0b",
                             res_bus.height, res_bus.in_hole));
      end else begin
        want = heights_due.pop_front();
        if (res_bus.height !== want.height || res_bus.in_hole !== want.in_hole) begin
          note_error($sformatf("height %0d hole %0b, expected height %0d hole %0b",
                               res_bus.height, res_bus.in_hole, want.height, want.in_hole));
        end
      end
    end
  end

  // Watchdog: end the run when no channel transfers for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_ifs.sv
hw/rtl/hbs_axis.sv
hw/rtl/hbs_grid_mem.sv
hw/rtl/hbs_blend.sv
hw/rtl/heightmap_bilinear_sampler.sv
tb/tb_heightmap_bilinear_sampler.sv
